// ===== hdl/ewms_pkg.sv =====
// Shared types, widths and constants of the weighted mean and variance unit.
package ewms_pkg;

    localparam int SampleW    = 16;
    localparam int DecayW     = 16;
    localparam int MeanW      = 32;
    localparam int VarW       = 46;
    localparam int RootW      = 23;
    localparam int CountW     = 32;
    localparam int SqrtSteps  = 23;
    localparam int BitW       = VarW - 1;
    localparam int FifoDepth  = 4;

    localparam logic [DecayW-1:0] DecayReset = 16'd58982;

    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic                      invalid;
    } t_item;

    typedef struct packed {
        logic                     status;
        logic signed [MeanW-1:0]  mean;
        logic        [VarW-1:0]   variance;
        logic        [CountW-1:0] count;
    } t_result;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL1,
        U_MUL2,
        U_MSQ,
        U_CMP,
        U_HOLD
    } t_upd_state;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_sqrt_state;

endpackage

// ===== hdl/ewma_mean_variance_stdev_unit.sv =====
// Top level: decay register, sample queue, update engine and square root unit.
// The square root loop sets the throughput: one root bit per cycle over 23 steps,
// plus load and hand-off, and it takes a new result only once the last is handed
// off; the update engine overlaps with it.
// Input stays open while the queue has room. Synchronous active-low reset
// clears averages, count, queue and control, and loads decay 58982.
module ewma_mean_variance_stdev_unit #(
    parameter int FIFO_DEPTH = ewms_pkg::FifoDepth
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic        [ewms_pkg::DecayW-1:0]  i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ewms_pkg::SampleW-1:0] i_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_status,
    output logic signed [ewms_pkg::MeanW-1:0]   o_mean,
    output logic        [ewms_pkg::VarW-1:0]    o_variance,
    output logic        [ewms_pkg::RootW-1:0]   o_std_deviation,
    output logic        [ewms_pkg::CountW-1:0]  o_update_count
);

    logic [ewms_pkg::DecayW-1:0] r_decay;
    logic                        item_valid;
    ewms_pkg::t_item             item;
    logic                        pop;
    logic                        res_valid;
    ewms_pkg::t_result           res;
    logic                        res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= ewms_pkg::DecayReset;
        end else if (i_cfg_we) begin
            r_decay <= i_cfg_data;
        end
    end

    ewms_front #(
        .DEPTH(FIFO_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_sample    (i_sample),
        .i_decay     (r_decay),
        .o_stall     (o_stall),
        .o_item_valid(item_valid),
        .o_item      (item),
        .i_pop       (pop)
    );

    ewms_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_decay     (r_decay),
        .i_item_valid(item_valid),
        .i_item      (item),
        .o_pop       (pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_stall (res_stall)
    );

    ewms_sqrt u_sqrt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res_valid    (res_valid),
        .i_res          (res),
        .o_res_stall    (res_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_mean         (o_mean),
        .o_variance     (o_variance),
        .o_std_deviation(o_std_deviation),
        .o_update_count (o_update_count)
    );

endmodule

// ===== hdl/ewms_front.sv =====
// Front end: accepts samples, classifies them by the decay setting and queues them.
module ewms_front #(
    parameter int DEPTH = ewms_pkg::FifoDepth
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [ewms_pkg::SampleW-1:0] i_sample,
    input  logic        [ewms_pkg::DecayW-1:0]  i_decay,
    output logic                                o_stall,
    output logic                                o_item_valid,
    output ewms_pkg::t_item                     o_item,
    input  logic                                i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ewms_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            push;
    logic            pop;
    ewms_pkg::t_item new_item;

    assign o_stall      = (r_count == CW'(DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && o_item_valid;

    // tag the item now; a zero decay means it passes through without an update
    assign new_item.sample  = i_sample;
    assign new_item.invalid = (i_decay == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count missed a push");

    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

endmodule

// ===== hdl/ewms_update.sv =====
// Back end update engine: weighted averages, update count and variance.
module ewms_update (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic        [ewms_pkg::DecayW-1:0] i_decay,
    input  logic                               i_item_valid,
    input  ewms_pkg::t_item                    i_item,
    output logic                               o_pop,
    output logic                               o_res_valid,
    output ewms_pkg::t_result                  o_res,
    input  logic                               i_res_stall
);

    ewms_pkg::t_upd_state r_state, n_state;

    logic signed [ewms_pkg::MeanW-1:0]   r_avg_sample;
    logic        [ewms_pkg::VarW-1:0]    r_avg_square;
    logic        [ewms_pkg::CountW-1:0]  r_count;
    logic signed [ewms_pkg::SampleW-1:0] r_x;
    logic                                r_inv;
    logic signed [48:0]                  r_p_as;
    logic signed [32:0]                  r_p_wx;
    logic        [30:0]                  r_xx;
    logic        [61:0]                  r_p_dsq;
    logic        [46:0]                  r_p_wxx;
    logic        [47:0]                  r_msq;
    logic        [ewms_pkg::VarW-1:0]    r_var;

    logic        [ewms_pkg::DecayW-1:0]  n_w;
    logic signed [48:0]                  n_p_as;
    logic signed [32:0]                  n_p_wx;
    logic signed [31:0]                  n_xx_full;
    logic        [61:0]                  n_p_dsq;
    logic        [46:0]                  n_p_wxx;
    logic signed [ewms_pkg::MeanW-1:0]   n_avg_sample;
    logic        [ewms_pkg::VarW-1:0]    n_avg_square;
    logic        [ewms_pkg::MeanW-1:0]   n_mag;
    logic        [63:0]                  n_msq_full;
    logic        [47:0]                  n_sq_ext;
    logic        [ewms_pkg::VarW-1:0]    n_var;

    // weight on the new sample, 65536 - decay; only used when decay is nonzero
    assign n_w = ~i_decay + ewms_pkg::DecayW'(1);

    assign n_p_as    = $signed({1'b0, i_decay}) * r_avg_sample;
    assign n_p_wx    = $signed({1'b0, n_w}) * r_x;
    assign n_xx_full = r_x * r_x;
    assign n_p_dsq   = i_decay * r_avg_square;
    assign n_p_wxx   = n_w * r_xx;

    // the sample term of each sum has sixteen zero fraction bits, so shift first
    assign n_avg_sample = r_p_as[47:16] + r_p_wx[31:0];
    assign n_avg_square = r_p_dsq[61:16] + r_p_wxx[ewms_pkg::VarW-1:0];

    assign n_mag      = r_avg_sample[ewms_pkg::MeanW-1] ? ewms_pkg::MeanW'(-r_avg_sample)
                                                        : r_avg_sample;
    assign n_msq_full = n_mag * n_mag;

    assign n_sq_ext = {2'b00, r_avg_square};
    assign n_var    = (n_sq_ext > r_msq) ? ewms_pkg::VarW'(n_sq_ext - r_msq) : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ewms_pkg::U_IDLE: if (i_item_valid) n_state = ewms_pkg::U_MUL1;
            ewms_pkg::U_MUL1: n_state = ewms_pkg::U_MUL2;
            ewms_pkg::U_MUL2: n_state = ewms_pkg::U_MSQ;
            ewms_pkg::U_MSQ:  n_state = ewms_pkg::U_CMP;
            ewms_pkg::U_CMP:  n_state = ewms_pkg::U_HOLD;
            ewms_pkg::U_HOLD: if (!i_res_stall) n_state = ewms_pkg::U_IDLE;
            default:          n_state = ewms_pkg::U_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ewms_pkg::U_IDLE: o_pop       = i_item_valid;
            ewms_pkg::U_HOLD: o_res_valid = 1'b1;
            default: begin
                o_pop       = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    assign o_res.status   = r_inv;
    assign o_res.mean     = r_avg_sample;
    assign o_res.variance = r_var;
    assign o_res.count    = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ewms_pkg::U_IDLE;
            r_avg_sample <= '0;
            r_avg_square <= '0;
            r_count      <= '0;
        end else begin
            r_state <= n_state;
            // hold the averages and the count for an invalid item
            if (r_state == ewms_pkg::U_MUL2 && !r_inv) begin
                r_avg_sample <= n_avg_sample;
                r_count      <= r_count + ewms_pkg::CountW'(1);
            end
            if (r_state == ewms_pkg::U_MSQ && !r_inv) begin
                r_avg_square <= n_avg_square;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x   <= i_item.sample;
            r_inv <= i_item.invalid;
        end
        if (r_state == ewms_pkg::U_MUL1) begin
            r_p_as  <= n_p_as;
            r_p_wx  <= n_p_wx;
            r_xx    <= n_xx_full[30:0];
            r_p_dsq <= n_p_dsq;
        end
        if (r_state == ewms_pkg::U_MUL2) begin
            r_p_wxx <= n_p_wxx;
        end
        if (r_state == ewms_pkg::U_MSQ) begin
            r_msq <= n_msq_full[63:16];
        end
        if (r_state == ewms_pkg::U_CMP) begin
            r_var <= n_var;
        end
    end

    a_var_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ewms_pkg::U_HOLD) |-> (r_var <= r_avg_square))
        else $error("variance above mean square");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ewms_pkg::U_MUL2 && !r_inv) |=> (r_count == $past(r_count) + 32'd1))
        else $error("update count did not advance");

    a_inv_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ewms_pkg::U_MSQ && r_inv) |=> $stable(r_avg_square))
        else $error("mean square changed on an invalid item");

    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ewms_pkg::U_MUL1))
        else $error("popped item not started");

endmodule

// ===== hdl/ewms_sqrt.sv =====
// Back end root unit: bit-serial integer square root and the result register.
module ewms_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_res_valid,
    input  ewms_pkg::t_result                   i_res,
    output logic                                o_res_stall,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_status,
    output logic signed [ewms_pkg::MeanW-1:0]   o_mean,
    output logic        [ewms_pkg::VarW-1:0]    o_variance,
    output logic        [ewms_pkg::RootW-1:0]   o_std_deviation,
    output logic        [ewms_pkg::CountW-1:0]  o_update_count
);

    localparam int StepW = $clog2(ewms_pkg::SqrtSteps);

    ewms_pkg::t_sqrt_state r_state, n_state;

    ewms_pkg::t_result           r_res;
    logic [ewms_pkg::VarW-1:0]   r_rem, n_rem;
    logic [ewms_pkg::VarW:0]     r_root, n_root;
    logic [ewms_pkg::BitW-1:0]   r_bit;
    logic [StepW-1:0]            r_step;
    logic [ewms_pkg::VarW:0]     n_trial;
    logic                        last_step;

    assign last_step = (r_step == StepW'(ewms_pkg::SqrtSteps - 1));

    // one root bit per cycle: try root + bit against the remainder
    assign n_trial = r_root + {2'b00, r_bit};
    always_comb begin
        if ({1'b0, r_rem} >= n_trial) begin
            n_rem  = r_rem - n_trial[ewms_pkg::VarW-1:0];
            n_root = (r_root >> 1) + {2'b00, r_bit};
        end else begin
            n_rem  = r_rem;
            n_root = r_root >> 1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ewms_pkg::S_IDLE: if (i_res_valid) n_state = ewms_pkg::S_RUN;
            ewms_pkg::S_RUN:  if (last_step) n_state = ewms_pkg::S_DONE;
            ewms_pkg::S_DONE: if (!i_stall) n_state = ewms_pkg::S_IDLE;
            default:          n_state = ewms_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_res_stall = 1'b1;
        o_valid     = 1'b0;
        case (r_state)
            ewms_pkg::S_IDLE: o_res_stall = 1'b0;
            ewms_pkg::S_DONE: o_valid     = 1'b1;
            default: begin
                o_res_stall = 1'b1;
                o_valid     = 1'b0;
            end
        endcase
    end

    assign o_status        = r_res.status;
    assign o_mean          = r_res.mean;
    assign o_variance      = r_res.variance;
    assign o_update_count  = r_res.count;
    assign o_std_deviation = r_root[ewms_pkg::RootW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ewms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ewms_pkg::S_IDLE: begin
                if (i_res_valid) begin
                    r_res  <= i_res;
                    r_rem  <= i_res.variance;
                    r_root <= '0;
                    r_bit  <= {1'b1, {(ewms_pkg::BitW - 1){1'b0}}};
                    r_step <= '0;
                end
            end
            ewms_pkg::S_RUN: begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_bit  <= r_bit >> 2;
                r_step <= r_step + StepW'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ewms_pkg::S_RUN && last_step) |=> (r_state == ewms_pkg::S_DONE))
        else $error("root loop overran its step count");

    a_bit_spent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ewms_pkg::S_DONE) |-> (r_bit == '0))
        else $error("root finished with bits left");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_root[ewms_pkg::VarW:ewms_pkg::RootW] == '0))
        else $error("root wider than its field");

    a_hold_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_root))
        else $error("root changed while result waited");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the weighted mean, variance and deviation unit.
module tb;
    import ewms_pkg::*;

    localparam int HalfPeriod   = 2;
    localparam int ResetCycles  = 12;
    localparam int SettleCycles = 40;
    localparam int RandomItems  = 500;
    localparam int ReportLimit  = 10;

    typedef enum logic [1:0] {
        JOB_SAMPLE,
        JOB_DECAY,
        JOB_DRAIN
    } t_job_kind;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_RUNS
    } t_stall_mode;

    typedef struct packed {
        t_job_kind         kind;
        logic [15:0]       value;
    } t_job;

    typedef struct packed {
        logic                     status;
        logic signed [MeanW-1:0]  mean;
        logic        [VarW-1:0]   variance;
        logic        [RootW-1:0]  root;
        logic        [CountW-1:0] count;
    } t_stats;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_cfg_we   = 1'b0;
    logic        [DecayW-1:0]  i_cfg_data = '0;
    logic                      i_valid    = 1'b0;
    logic signed [SampleW-1:0] i_sample   = '0;
    logic                      i_stall    = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic                      o_status;
    logic signed [MeanW-1:0]   o_mean;
    logic        [VarW-1:0]    o_variance;
    logic        [RootW-1:0]   o_std_deviation;
    logic        [CountW-1:0]  o_update_count;

    ewma_mean_variance_stdev_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_mean          (o_mean),
        .o_variance      (o_variance),
        .o_std_deviation (o_std_deviation),
        .o_update_count  (o_update_count)
    );

    t_job   job_q[$];
    t_stats stats_q[$];

    // running copy of the block's averages and decay
    logic        [DecayW-1:0] decay_reg;
    logic signed [MeanW-1:0]  mean_acc;
    logic        [VarW-1:0]   square_acc;
    logic        [CountW-1:0] updates;

    int items_sent      = 0;
    int results_checked = 0;
    int invalid_seen    = 0;
    int mismatches      = 0;
    int decay_writes    = 0;
    int drains          = 0;
    int quiet_cycles    = 0;
    bit took_item       = 1'b0;

    int          burst_left = 1;
    int          gap_left   = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;
    logic        run_level  = 1'b0;

    always #HalfPeriod i_clk = ~i_clk;

    function automatic logic [RootW-1:0] int_root(logic [63:0] v);
        logic [63:0] acc_root;
        logic [63:0] probe;
        acc_root = '0;
        probe    = 64'd1 << 46;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= acc_root + probe) begin
                v        = v - (acc_root + probe);
                acc_root = (acc_root >> 1) + probe;
            end else begin
                acc_root = acc_root >> 1;
            end
            probe = probe >> 2;
        end
        return acc_root[RootW-1:0];
    endfunction

    // Fold one sample into the averages and return the stats it yields.
    function automatic t_stats advance_stats(logic signed [SampleW-1:0] x);
        t_stats             r;
        logic signed [63:0] xs;
        logic signed [63:0] dl;
        logic signed [63:0] wl;
        logic signed [63:0] acc;
        logic signed [63:0] mm;
        logic        [63:0] du;
        logic        [63:0] wu;
        logic        [63:0] sq;
        logic        [63:0] acc2;
        logic        [63:0] mag;
        logic        [63:0] msq;
        logic        [63:0] var_raw;
        xs       = x;
        r.status = 1'b0;
        if (decay_reg == '0) begin
            r.status = 1'b1;
        end else begin
            dl         = {48'd0, decay_reg};
            wl         = 64'sd65536 - dl;
            acc        = dl * mean_acc + wl * (xs <<< 16);
            acc        = acc >>> 16;
            mean_acc   = acc[MeanW-1:0];
            du         = {48'd0, decay_reg};
            wu         = 64'd65536 - du;
            sq         = xs * xs;
            sq         = sq << 16;
            acc2       = du * {18'd0, square_acc} + wu * sq;
            square_acc = acc2[61:16];
            updates    = updates + CountW'(1);
        end
        mm      = mean_acc;
        mag     = (mm < 0) ? -mm : mm;
        msq     = (mag * mag) >> 16;
        var_raw = ({18'd0, square_acc} > msq) ? {18'd0, square_acc} - msq : 64'd0;
        r.mean     = mean_acc;
        r.variance = var_raw[VarW-1:0];
        r.root     = int_root(var_raw);
        r.count    = updates;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= ReportLimit)
                $display("mismatch in %s of result %0d: expected %0h, got %0h",
                         name, results_checked, want, got);
        end
    endtask

    task automatic push_job(t_job_kind kind, logic [15:0] value);
        t_job j;
        j.kind  = kind;
        j.value = value;
        job_q.push_back(j);
    endtask

    // Predict on accepted items and check accepted results.
    always @(posedge i_clk) begin : scoreboard
        t_stats want;
        if (!i_rst_n) begin
            decay_reg    = DecayReset;
            mean_acc     = '0;
            square_acc   = '0;
            updates      = '0;
            took_item    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (i_cfg_we) decay_reg = i_cfg_data;
            if (i_valid && !o_stall) begin
                stats_q.push_back(advance_stats(i_sample));
                items_sent++;
            end
            if (o_valid === 1'b1 && !i_stall) begin
                if (stats_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= ReportLimit)
                        $display("result with no sample pending: mean %0h count %0h",
                                 o_mean, o_update_count);
                end else begin
                    want = stats_q.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("mean", want.mean, o_mean);
                    check_field("variance", want.variance, o_variance);
                    check_field("std_deviation", want.root, o_std_deviation);
                    check_field("update_count", want.count, o_update_count);
                    if (want.status) invalid_seen++;
                    results_checked++;
                end
            end
            took_item    <= i_valid && !o_stall;
            quiet_cycles <= (stats_q.size() == 0 && !i_valid) ? quiet_cycles + 1 : 0;
        end
    end

    always @(negedge i_clk) begin : driver
        t_job                      head;
        logic                      nv;
        logic                      nwe;
        logic        [DecayW-1:0]  ndata;
        logic signed [SampleW-1:0] nsample;
        nv      = i_valid;
        nwe     = 1'b0;
        ndata   = i_cfg_data;
        nsample = i_sample;
        // hold a stalled item as it is
        if (i_rst_n && !(i_valid && !took_item)) begin
            nv = 1'b0;
            if (job_q.size() != 0) begin
                head = job_q[0];
                case (head.kind)
                    JOB_SAMPLE: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            nv      = 1'b1;
                            nsample = head.value;
                            void'(job_q.pop_front());
                            burst_left--;
                            if (burst_left <= 0) begin
                                burst_left = $urandom_range(1, 16);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                        : $urandom_range(1, 60);
                            end
                        end
                    end
                    JOB_DECAY: begin
                        // write only once the unit has gone quiet
                        if (stats_q.size() == 0 && quiet_cycles >= SettleCycles) begin
                            nwe   = 1'b1;
                            ndata = head.value;
                            void'(job_q.pop_front());
                            decay_writes++;
                        end
                    end
                    default: begin
                        if (stats_q.size() == 0) begin
                            void'(job_q.pop_front());
                            drains++;
                        end
                    end
                endcase
            end
        end
        i_valid    <= nv;
        i_cfg_we   <= nwe;
        i_cfg_data <= ndata;
        i_sample   <= nsample;
    end

    always @(negedge i_clk) begin : receiver
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(100, 400);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE: i_stall <= 1'b0;
            STALL_COIN: i_stall <= 1'($urandom_range(0, 1));
            default: begin
                if (run_left == 0) begin
                    run_level = 1'($urandom_range(0, 1));
                    run_left  = $urandom_range(1, 40);
                end else begin
                    run_left--;
                end
                i_stall <= run_level;
            end
        endcase
    end

    initial begin : limit
        #2400000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        int          n;
        int          phase_len;
        logic [15:0] dv;
        logic [15:0] level;
        logic [15:0] s;

        // reset decay, full-scale and bit-pattern samples
        push_job(JOB_SAMPLE, 16'h8000);
        push_job(JOB_SAMPLE, 16'h8000);
        push_job(JOB_SAMPLE, 16'h7FFF);
        push_job(JOB_SAMPLE, 16'h7FFF);
        push_job(JOB_SAMPLE, 16'h0000);
        push_job(JOB_SAMPLE, 16'hFFFF);
        push_job(JOB_SAMPLE, 16'h0001);
        push_job(JOB_SAMPLE, 16'h5555);
        push_job(JOB_SAMPLE, 16'hAAAA);
        // smallest decay: average of the square runs right up to full scale
        push_job(JOB_DECAY, 16'd1);
        push_job(JOB_SAMPLE, 16'h8000);
        push_job(JOB_SAMPLE, 16'h8000);
        push_job(JOB_SAMPLE, 16'h8000);
        push_job(JOB_SAMPLE, 16'h7FFF);
        push_job(JOB_SAMPLE, 16'h8000);
        // zero decay: no update, status set
        push_job(JOB_DECAY, 16'd0);
        push_job(JOB_SAMPLE, 16'h0064);
        push_job(JOB_SAMPLE, 16'h8000);
        push_job(JOB_DECAY, 16'hFFFF);
        push_job(JOB_SAMPLE, 16'h7FFF);
        push_job(JOB_SAMPLE, 16'h8000);
        push_job(JOB_SAMPLE, 16'h7FFF);
        push_job(JOB_DECAY, 16'h8000);
        push_job(JOB_SAMPLE, 16'h8000);
        push_job(JOB_SAMPLE, 16'h7FFF);
        push_job(JOB_SAMPLE, 16'h0000);

        n = 0;
        while (n < RandomItems) begin
            case ($urandom_range(0, 7))
                0:       dv = 16'd1;
                1:       dv = 16'hFFFF;
                2:       dv = 16'd0;
                3:       dv = 16'h8000;
                4:       dv = DecayReset;
                default: dv = 16'($urandom_range(1, 65535));
            endcase
            push_job(JOB_DECAY, dv);
            phase_len = (dv == 0) ? $urandom_range(3, 8) : $urandom_range(30, 80);
            level     = 16'($urandom_range(0, 65535));
            repeat (phase_len) begin
                if (n == RandomItems / 2 || $urandom_range(0, 39) == 0)
                    push_job(JOB_DRAIN, 16'd0);
                case ($urandom_range(0, 3))
                    0: s = 16'($urandom_range(0, 65535));
                    1: s = level + 16'($urandom_range(0, 63)) - 16'd32;
                    2: begin
                        case ($urandom_range(0, 3))
                            0:       s = 16'h8000;
                            1:       s = 16'h7FFF;
                            2:       s = 16'h0000;
                            default: s = 16'hFFFF;
                        endcase
                    end
                    default: s = n[0] ? 16'h8000 + 16'($urandom_range(0, 4095))
                                      : 16'h7FFF - 16'($urandom_range(0, 4095));
                endcase
                push_job(JOB_SAMPLE, s);
                n++;
            end
        end

        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || i_valid || stats_q.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);

        $display("run covered %0d samples across %0d decay settings, %0d full drains",
                 items_sent, decay_writes, drains);
        $display("checked %0d results, %0d with invalid decay, %0d mismatches",
                 results_checked, invalid_seen, mismatches);
        if (mismatches == 0 && stats_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
